/* sv/cau_pkg.sv */
// Package for the complex arithmetic unit.
// Opcode encoding and the per-transaction flag bundle; no dependencies.
package cau_pkg;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_CONJ = 3'd4,
      OP_CMP  = 3'd5
   } op_type;

   typedef struct packed {
      logic use_div;   // result comes from the divider
      logic neg_re;
      logic neg_im;
      logic qovf_re;   // quotient too large, saturate
      logic qovf_im;
      logic ovf;
      logic div_zero;
      logic equal;
   } cau_flags_type;

endpackage

/* sv/cau_req_if.sv */
// Request channel: opcode and two complex operands, valid/ready handshake.
// No dependencies.
interface cau_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        opcode;
   logic signed [31:0] a_re;
   logic signed [31:0] a_im;
   logic signed [31:0] b_re;
   logic signed [31:0] b_im;

   modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

/* sv/cau_rsp_if.sv */
// Response channel: complex result and status flags, valid/ready handshake.
// No dependencies.
interface cau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_re;
   logic signed [31:0] res_im;
   logic               div_zero;
   logic               overflow;
   logic               equal;

   modport source (output valid, res_re, res_im, div_zero, overflow, equal, input ready);
   modport sink   (input valid, res_re, res_im, div_zero, overflow, equal, output ready);
endinterface

/* sv/complex_arithmetic_unit.sv */
// Complex arithmetic unit, signed fixed point, saturating.
// Channels: req_ch (sink) carries opcode and operands a, b; rsp_ch (source)
// carries res_re, res_im, div_zero, overflow, equal. A transaction moves when
// valid and ready are both high at a rising clock edge.
// Opcodes: add, subtract, multiply, divide, conjugate of a, compare; the
// two unused codes give an all-zero result.
// Every opcode runs through the same pipeline: five front stages (capture,
// products, sums, magnitudes, quotient range check), DATA_WIDTH+1 restoring
// divider stages, one quotient bit per stage, and an output register.
// One transaction is taken per cycle unless a stall on rsp_ch backs up the
// pipeline; results leave in order.
// Each stage holds its data while the next is full and stalled; bubbles are
// squeezed out, so req_ch stays ready unless all stages are full and stalled.
// Synchronous reset clears all valid bits; no result is pending afterwards.
// Depends on cau_pkg, cau_req_if, cau_rsp_if, cau_front, cau_div_step.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   cau_req_if.sink   req_ch,
   cau_rsp_if.source rsp_ch
);

   localparam int W = DATA_WIDTH;
   localparam int F = FRAC_BITS;
   localparam int N = W + 2;

   logic           c_valid  [N];
   logic           c_ready  [N];
   cau_flags_type  c_flags  [N];
   logic [W-1:0]   c_fre    [N];
   logic [W-1:0]   c_fim    [N];
   logic [2*W:0]   c_mre    [N];
   logic [2*W:0]   c_mim    [N];
   logic [2*W-1:0] c_den    [N];
   logic [2*W-1:0] c_rre    [N];
   logic [2*W-1:0] c_rim    [N];
   logic [W:0]     c_qre    [N];
   logic [W:0]     c_qim    [N];

   cau_front #(.W(W), .F(F)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_opcode  (req_ch.opcode),
      .in_a_re    (req_ch.a_re),
      .in_a_im    (req_ch.a_im),
      .in_b_re    (req_ch.b_re),
      .in_b_im    (req_ch.b_im),
      .out_valid  (c_valid[0]),
      .out_ready  (c_ready[0]),
      .out_flags  (c_flags[0]),
      .out_fre    (c_fre[0]),
      .out_fim    (c_fim[0]),
      .out_mag_re (c_mre[0]),
      .out_mag_im (c_mim[0]),
      .out_den    (c_den[0]),
      .out_rem_re (c_rre[0]),
      .out_rem_im (c_rim[0])
   );

   assign c_qre[0] = '0;
   assign c_qim[0] = '0;

   generate
      for (genvar g = 0; g <= W; g++) begin : g_div
         cau_div_step #(.W(W), .F(F), .K(W - g)) u_step (
            .clock      (clock),
            .reset      (reset),
            .in_valid   (c_valid[g]),
            .in_ready   (c_ready[g]),
            .in_flags   (c_flags[g]),
            .in_fre     (c_fre[g]),
            .in_fim     (c_fim[g]),
            .in_mag_re  (c_mre[g]),
            .in_mag_im  (c_mim[g]),
            .in_den     (c_den[g]),
            .in_rem_re  (c_rre[g]),
            .in_rem_im  (c_rim[g]),
            .in_q_re    (c_qre[g]),
            .in_q_im    (c_qim[g]),
            .out_valid  (c_valid[g+1]),
            .out_ready  (c_ready[g+1]),
            .out_flags  (c_flags[g+1]),
            .out_fre    (c_fre[g+1]),
            .out_fim    (c_fim[g+1]),
            .out_mag_re (c_mre[g+1]),
            .out_mag_im (c_mim[g+1]),
            .out_den    (c_den[g+1]),
            .out_rem_re (c_rre[g+1]),
            .out_rem_im (c_rim[g+1]),
            .out_q_re   (c_qre[g+1]),
            .out_q_im   (c_qim[g+1])
         );
      end
   endgenerate

   localparam logic [W:0]   QMAXP = (W+1)'((64'd1 << (W-1)) - 64'd1);
   localparam logic [W:0]   QMAXN = (W+1)'(64'd1 << (W-1));
   localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN  = {1'b1, {(W-1){1'b0}}};

   // {overflow, value} of a signed quotient
   function automatic logic [W:0] qres(input logic neg, input logic qovf,
                                       input logic [W:0] q);
      logic [W:0] nq;
      nq = -q;
      if (!neg && (qovf || q > QMAXP)) return {1'b1, VMAX};
      if (neg && (qovf || q > QMAXN)) return {1'b1, VMIN};
      return neg ? {1'b0, nq[W-1:0]} : {1'b0, q[W-1:0]};
   endfunction

   cau_flags_type fl;
   logic [W:0]    dr, di;
   logic [W-1:0]  re_in, im_in;
   logic          ov_in;

   assign fl = c_flags[N-1];
   assign dr = qres(fl.neg_re, fl.qovf_re, c_qre[N-1]);
   assign di = qres(fl.neg_im, fl.qovf_im, c_qim[N-1]);

   always_comb begin
      if (fl.use_div) begin
         re_in = dr[W-1:0];
         im_in = di[W-1:0];
         ov_in = dr[W] | di[W];
      end else begin
         re_in = c_fre[N-1];
         im_in = c_fim[N-1];
         ov_in = fl.ovf;
      end
   end

   logic               rv_ff, ren;
   logic signed [W-1:0] re_ff, im_ff;
   logic               dz_ff, ov_ff, eq_ff;

   assign ren = !rv_ff || rsp_ch.ready;
   assign c_ready[N-1] = ren;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (ren) begin
         rv_ff <= c_valid[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ren) begin
         re_ff <= $signed(re_in);
         im_ff <= $signed(im_in);
         dz_ff <= fl.div_zero;
         ov_ff <= ov_in;
         eq_ff <= fl.equal;
      end
   end

   assign rsp_ch.valid    = rv_ff;
   assign rsp_ch.res_re   = 32'(re_ff);
   assign rsp_ch.res_im   = 32'(im_ff);
   assign rsp_ch.div_zero = dz_ff;
   assign rsp_ch.overflow = ov_ff;
   assign rsp_ch.equal    = eq_ff;

endmodule

/* sv/cau_front.sv */
// Front pipeline: operand capture, products, sums, magnitudes, divider setup.
// Five register stages. Depends on cau_pkg.
module cau_front
   import cau_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [2:0]          in_opcode,
   input  logic [31:0]         in_a_re,
   input  logic [31:0]         in_a_im,
   input  logic [31:0]         in_b_re,
   input  logic [31:0]         in_b_im,
   output logic                out_valid,
   input  logic                out_ready,
   output cau_flags_type       out_flags,
   output logic [W-1:0]        out_fre,
   output logic [W-1:0]        out_fim,
   output logic [2*W:0]        out_mag_re,
   output logic [2*W:0]        out_mag_im,
   output logic [2*W-1:0]      out_den,
   output logic [2*W-1:0]      out_rem_re,
   output logic [2*W-1:0]      out_rem_im
);

   localparam int XW = 2*W + 2;
   localparam int NW = 2*W + 1 + F;
   localparam logic signed [XW-1:0] SMAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] SMIN = ~SMAX;

   function automatic logic signed [XW-1:0] sx(input logic signed [W-1:0] v);
      return XW'(v);
   endfunction

   // {overflow, saturated value}
   function automatic logic [W:0] sat(input logic signed [XW-1:0] v);
      if (v > SMAX) return {1'b1, SMAX[W-1:0]};
      if (v < SMIN) return {1'b1, SMIN[W-1:0]};
      return {1'b0, v[W-1:0]};
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || out_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // stage 1: capture
   op_type             op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff <= op_type'(in_opcode);
         ar1_ff <= $signed(in_a_re[W-1:0]);
         ai1_ff <= $signed(in_a_im[W-1:0]);
         br1_ff <= $signed(in_b_re[W-1:0]);
         bi1_ff <= $signed(in_b_im[W-1:0]);
      end
   end

   // stage 2: products and part-wise operations
   logic signed [2*W-1:0] prr2_in, pii2_in, pri2_in, pir2_in, pbr2_in, pbi2_in;
   logic signed [2*W-1:0] prr2_ff, pii2_ff, pri2_ff, pir2_ff, pbr2_ff, pbi2_ff;
   op_type                op2_ff;
   cau_flags_type         fl2_in, fl2_ff;
   logic [W-1:0]          fre2_in, fim2_in, fre2_ff, fim2_ff;

   assign prr2_in = ar1_ff * br1_ff;
   assign pii2_in = ai1_ff * bi1_ff;
   assign pri2_in = ar1_ff * bi1_ff;
   assign pir2_in = ai1_ff * br1_ff;
   assign pbr2_in = br1_ff * br1_ff;
   assign pbi2_in = bi1_ff * bi1_ff;

   always_comb begin
      logic [W:0] sr, si;
      sr = '0;
      si = '0;
      fl2_in = '0;
      fre2_in = '0;
      fim2_in = '0;
      unique case (op1_ff)
         OP_ADD: begin
            sr = sat(sx(ar1_ff) + sx(br1_ff));
            si = sat(sx(ai1_ff) + sx(bi1_ff));
         end
         OP_SUB: begin
            sr = sat(sx(ar1_ff) - sx(br1_ff));
            si = sat(sx(ai1_ff) - sx(bi1_ff));
         end
         OP_CONJ: begin
            sr = sat(sx(ar1_ff));
            si = sat(-sx(ai1_ff));
         end
         OP_DIV: begin
            if (br1_ff == '0 && bi1_ff == '0) begin
               sr = {1'b0, ar1_ff};
               si = {1'b0, ai1_ff};
               fl2_in.div_zero = 1'b1;
            end else begin
               fl2_in.use_div = 1'b1;
            end
         end
         OP_CMP: fl2_in.equal = (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         default: ;
      endcase
      fre2_in = sr[W-1:0];
      fim2_in = si[W-1:0];
      fl2_in.ovf = sr[W] | si[W];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         prr2_ff <= prr2_in;
         pii2_ff <= pii2_in;
         pri2_ff <= pri2_in;
         pir2_ff <= pir2_in;
         pbr2_ff <= pbr2_in;
         pbi2_ff <= pbi2_in;
         op2_ff  <= op1_ff;
         fl2_ff  <= fl2_in;
         fre2_ff <= fre2_in;
         fim2_ff <= fim2_in;
      end
   end

   // stage 3: sums of products and divisor norm
   logic signed [2*W:0] sre3_in, sim3_in, sre3_ff, sim3_ff;
   logic [2*W-1:0]      den3_in, den3_ff;
   op_type              op3_ff;
   cau_flags_type       fl3_ff;
   logic [W-1:0]        fre3_ff, fim3_ff;

   always_comb begin
      logic signed [2*W:0] xrr, xii, xri, xir;
      xrr = (2*W+1)'(prr2_ff);
      xii = (2*W+1)'(pii2_ff);
      xri = (2*W+1)'(pri2_ff);
      xir = (2*W+1)'(pir2_ff);
      if (op2_ff == OP_MUL) begin
         sre3_in = xrr - xii;
         sim3_in = xri + xir;
      end else begin
         sre3_in = xrr + xii;
         sim3_in = xir - xri;
      end
      den3_in = $unsigned(pbr2_ff) + $unsigned(pbi2_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         sre3_ff <= sre3_in;
         sim3_ff <= sim3_in;
         den3_ff <= den3_in;
         op3_ff  <= op2_ff;
         fl3_ff  <= fl2_ff;
         fre3_ff <= fre2_ff;
         fim3_ff <= fim2_ff;
      end
   end

   // stage 4: magnitudes for the divider, multiply result
   logic [2*W:0]   mre4_in, mim4_in, mre4_ff, mim4_ff;
   logic [2*W-1:0] den4_ff;
   cau_flags_type  fl4_in, fl4_ff;
   logic [W-1:0]   fre4_in, fim4_in, fre4_ff, fim4_ff;

   always_comb begin
      logic [W:0] sr, si;
      fl4_in  = fl3_ff;
      fre4_in = fre3_ff;
      fim4_in = fim3_ff;
      fl4_in.neg_re = sre3_ff[2*W];
      fl4_in.neg_im = sim3_ff[2*W];
      mre4_in = sre3_ff[2*W] ? $unsigned(-sre3_ff) : $unsigned(sre3_ff);
      mim4_in = sim3_ff[2*W] ? $unsigned(-sim3_ff) : $unsigned(sim3_ff);
      sr = sat(XW'(sre3_ff >>> F));
      si = sat(XW'(sim3_ff >>> F));
      if (op3_ff == OP_MUL) begin
         fre4_in = sr[W-1:0];
         fim4_in = si[W-1:0];
         fl4_in.ovf = sr[W] | si[W];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         mre4_ff <= mre4_in;
         mim4_ff <= mim4_in;
         den4_ff <= den3_ff;
         fl4_ff  <= fl4_in;
         fre4_ff <= fre4_in;
         fim4_ff <= fim4_in;
      end
   end

   // stage 5: quotient range check and initial remainder
   logic [NW-1:0]  hre5, him5;
   logic [NW-1:0]  dext5;
   cau_flags_type  fl5_in, fl5_ff;
   logic [2*W:0]   mre5_ff, mim5_ff;
   logic [2*W-1:0] den5_ff, rre5_ff, rim5_ff;
   logic [W-1:0]   fre5_ff, fim5_ff;

   assign hre5  = (NW'(mre4_ff) << F) >> (W + 1);
   assign him5  = (NW'(mim4_ff) << F) >> (W + 1);
   assign dext5 = NW'(den4_ff);

   always_comb begin
      fl5_in = fl4_ff;
      fl5_in.qovf_re = hre5 >= dext5;
      fl5_in.qovf_im = him5 >= dext5;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         fl5_ff  <= fl5_in;
         mre5_ff <= mre4_ff;
         mim5_ff <= mim4_ff;
         den5_ff <= den4_ff;
         rre5_ff <= hre5[2*W-1:0];
         rim5_ff <= him5[2*W-1:0];
         fre5_ff <= fre4_ff;
         fim5_ff <= fim4_ff;
      end
   end

   assign out_valid  = v5_ff;
   assign out_flags  = fl5_ff;
   assign out_fre    = fre5_ff;
   assign out_fim    = fim5_ff;
   assign out_mag_re = mre5_ff;
   assign out_mag_im = mim5_ff;
   assign out_den    = den5_ff;
   assign out_rem_re = rre5_ff;
   assign out_rem_im = rim5_ff;

endmodule

/* sv/cau_div_step.sv */
// One restoring division step for both result parts, one register stage.
// Quotient bit K of (magnitude << F) / den. Depends on cau_pkg.
module cau_div_step
   import cau_pkg::*;
#(
   parameter int W = 32,
   parameter int F = 16,
   parameter int K = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  cau_flags_type  in_flags,
   input  logic [W-1:0]   in_fre,
   input  logic [W-1:0]   in_fim,
   input  logic [2*W:0]   in_mag_re,
   input  logic [2*W:0]   in_mag_im,
   input  logic [2*W-1:0] in_den,
   input  logic [2*W-1:0] in_rem_re,
   input  logic [2*W-1:0] in_rem_im,
   input  logic [W:0]     in_q_re,
   input  logic [W:0]     in_q_im,
   output logic           out_valid,
   input  logic           out_ready,
   output cau_flags_type  out_flags,
   output logic [W-1:0]   out_fre,
   output logic [W-1:0]   out_fim,
   output logic [2*W:0]   out_mag_re,
   output logic [2*W:0]   out_mag_im,
   output logic [2*W-1:0] out_den,
   output logic [2*W-1:0] out_rem_re,
   output logic [2*W-1:0] out_rem_im,
   output logic [W:0]     out_q_re,
   output logic [W:0]     out_q_im
);

   logic nb_re, nb_im;

   generate
      if (K >= F) begin : g_bit
         assign nb_re = in_mag_re[K-F];
         assign nb_im = in_mag_im[K-F];
      end else begin : g_zero
         assign nb_re = 1'b0;
         assign nb_im = 1'b0;
      end
   endgenerate

   logic [2*W:0]   tre, tim, dext, dre, dim;
   logic           ge_re, ge_im;
   logic [2*W-1:0] rre_in, rim_in;

   assign dext  = {1'b0, in_den};
   assign tre   = {in_rem_re, nb_re};
   assign tim   = {in_rem_im, nb_im};
   assign ge_re = tre >= dext;
   assign ge_im = tim >= dext;
   assign dre   = ge_re ? tre - dext : tre;
   assign dim   = ge_im ? tim - dext : tim;
   assign rre_in = dre[2*W-1:0];
   assign rim_in = dim[2*W-1:0];

   logic v_ff, en;
   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   cau_flags_type  fl_ff;
   logic [W-1:0]   fre_ff, fim_ff;
   logic [2*W:0]   mre_ff, mim_ff;
   logic [2*W-1:0] den_ff, rre_ff, rim_ff;
   logic [W:0]     qre_ff, qim_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         fl_ff  <= in_flags;
         fre_ff <= in_fre;
         fim_ff <= in_fim;
         mre_ff <= in_mag_re;
         mim_ff <= in_mag_im;
         den_ff <= in_den;
         rre_ff <= rre_in;
         rim_ff <= rim_in;
         qre_ff <= {in_q_re[W-1:0], ge_re};
         qim_ff <= {in_q_im[W-1:0], ge_im};
      end
   end

   assign out_valid  = v_ff;
   assign out_flags  = fl_ff;
   assign out_fre    = fre_ff;
   assign out_fim    = fim_ff;
   assign out_mag_re = mre_ff;
   assign out_mag_im = mim_ff;
   assign out_den    = den_ff;
   assign out_rem_re = rre_ff;
   assign out_rem_im = rim_ff;
   assign out_q_re   = qre_ff;
   assign out_q_im   = qim_ff;

endmodule

/* test/tb_complex_arithmetic_unit.sv */
// Testbench for complex_arithmetic_unit: directed and random transactions
// checked against an in-bench fixed-point predictor.
// Depends on cau_pkg, cau_req_if, cau_rsp_if and the RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit
   import cau_pkg::*;
;

   localparam int FRAC = 16;
   localparam int LAT  = 39;

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic dz;
      logic ov;
      logic eq;
   } cplx_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   cau_req_if req_ch ();
   cau_rsp_if rsp_ch ();

   complex_arithmetic_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   cplx_res_type expected_q[$];
   int  errors = 0;
   int  n_sent = 0;
   int  n_checked = 0;
   bit  idle_on = 1'b1;

   function automatic logic signed [31:0] saturate(logic signed [127:0] v, ref logic ov);
      if (v > 128'sd2147483647) begin
         ov = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         ov = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // truncating quotient of (num * 2^FRAC) / den, magnitude clamped to 2^40
   function automatic logic signed [127:0] quot_trunc(logic signed [127:0] num,
                                                       logic signed [127:0] den);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag << FRAC) / den;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return (num < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic cplx_res_type compute_complex(logic [2:0] op, logic signed [31:0] ar,
         logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi);
      cplx_res_type r;
      logic signed [127:0] rr, ri, den, sa, sb, sc, sd;
      logic ov;
      rr = 0; ri = 0; ov = 1'b0;
      r.dz = 1'b0; r.eq = 1'b0;
      sa = ar; sb = ai; sc = br; sd = bi;
      unique case (op)
         OP_ADD: begin rr = sa + sc; ri = sb + sd; end
         OP_SUB: begin rr = sa - sc; ri = sb - sd; end
         OP_MUL: begin
            rr = (sa * sc - sb * sd) >>> FRAC;
            ri = (sa * sd + sb * sc) >>> FRAC;
            if (rr > (128'sd1 << 40)) rr = 128'sd1 << 40;
            if (rr < -(128'sd1 << 40)) rr = -(128'sd1 << 40);
            if (ri > (128'sd1 << 40)) ri = 128'sd1 << 40;
            if (ri < -(128'sd1 << 40)) ri = -(128'sd1 << 40);
         end
         OP_DIV: begin
            den = sc * sc + sd * sd;
            if (den == 0) begin
               rr = sa; ri = sb; r.dz = 1'b1;
            end else begin
               rr = quot_trunc(sa * sc + sb * sd, den);
               ri = quot_trunc(sb * sc - sa * sd, den);
            end
         end
         OP_CONJ: begin rr = sa; ri = -sb; end
         OP_CMP: r.eq = (ar == br) && (ai == bi);
         default: ;
      endcase
      r.re = saturate(rr, ov);
      r.im = saturate(ri, ov);
      r.ov = ov;
      return r;
   endfunction

   task automatic send_item(logic [2:0] op, logic signed [31:0] ar, logic signed [31:0] ai,
                            logic signed [31:0] br, logic signed [31:0] bi);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.a_re   <= ar;
      req_ch.a_im   <= ai;
      req_ch.b_re   <= br;
      req_ch.b_im   <= bi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(compute_complex(op, ar, ai, br, bi));
      n_sent++;
      @(negedge clock);
   endtask

   // ready side: random stall bursts
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cplx_res_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected transaction re=%h im=%h", rsp_ch.res_re, rsp_ch.res_im);
            errors++;
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            if (rsp_ch.res_re !== e.re) begin
               $error("res_re expected %h actual %h", e.re, rsp_ch.res_re); errors++;
            end
            if (rsp_ch.res_im !== e.im) begin
               $error("res_im expected %h actual %h", e.im, rsp_ch.res_im); errors++;
            end
            if (rsp_ch.div_zero !== e.dz) begin
               $error("div_zero expected %b actual %b", e.dz, rsp_ch.div_zero); errors++;
            end
            if (rsp_ch.overflow !== e.ov) begin
               $error("overflow expected %b actual %b", e.ov, rsp_ch.overflow); errors++;
            end
            if (rsp_ch.equal !== e.eq) begin
               $error("equal expected %b actual %b", e.eq, rsp_ch.equal); errors++;
            end
         end
      end
   end

   function automatic logic signed [31:0] rand_operand();
      unique case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3) == 0 ? 32'sh80000000 : 32'sh7fffffff;
         1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         2: return 32'sh0;
         3: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] mx, mn;
      mx = 32'sh7fffffff; mn = 32'sh80000000;
      send_item(OP_ADD, mx, mn, mx, mn);
      send_item(OP_ADD, 32'sh10000, -32'sh8000, 32'sh20000, 32'sh4000);
      send_item(OP_SUB, mn, mx, mx, mn);
      send_item(OP_SUB, 32'sh30000, 32'sh1, 32'sh10000, 32'sh2);
      send_item(OP_MUL, 32'sh20000, 32'sh10000, 32'sh30000, -32'sh10000);
      send_item(OP_MUL, mx, mx, mx, mn);
      send_item(OP_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0);
      send_item(OP_DIV, 32'sh50000, 32'sh0, 32'sh20000, 32'sh0);
      send_item(OP_DIV, 32'sh12345, -32'sh6789, 32'sh0, 32'sh0);
      send_item(OP_DIV, mx, mn, 32'sh1, 32'sh0);
      send_item(OP_DIV, -32'sh10000, 32'sh10000, 32'sh30000, 32'sh0);
      send_item(OP_CONJ, 32'sh1234, mn, 32'sh0, 32'sh0);
      send_item(OP_CONJ, mn, mx, 32'sh5, 32'sh6);
      send_item(OP_CMP, 32'sh11, 32'sh22, 32'sh11, 32'sh22);
      send_item(OP_CMP, 32'sh11, 32'sh22, 32'sh11, 32'sh23);
      send_item(3'd6, mx, mx, mx, mx);
      send_item(3'd7, mn, mn, mn, mn);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   task automatic test_random(int count);
      logic [2:0] op;
      logic signed [31:0] ar, ai, br, bi;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
         ar = rand_operand(); ai = rand_operand();
         br = rand_operand(); bi = rand_operand();
         if (op == OP_CMP && $urandom_range(0, 1)) begin
            br = ar;
            if ($urandom_range(0, 1)) bi = ai;
         end
         if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
            br = 0; bi = 0;
         end
         send_item(op, ar, ai, br, bi);
      end
   endtask

   task automatic test_back_to_back(int count);
      idle_on = 1'b0;
      test_random(count);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.opcode <= OP_ADD;
      req_ch.a_re <= '0; req_ch.a_im <= '0;
      req_ch.b_re <= '0; req_ch.b_im <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      drain();
      test_random(1300);
      test_back_to_back(400);
      drain();
      repeat (LAT + 10) @(negedge clock);
      $display("covered %0d transactions, %0d results checked: all opcodes, extremes,",
               n_sent, n_checked);
      $display("zero divisors, saturation, compare hits and misses, unused codes");
      if (errors == 0 && expected_q.size() == 0)
         $display("tb_complex_arithmetic_unit OK");
      else
         $display("tb_complex_arithmetic_unit NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_complex_arithmetic_unit NOT OK");
      $finish;
   end

endmodule

/* complex_arithmetic_unit.f */
sv/cau_pkg.sv
sv/cau_req_if.sv
sv/cau_rsp_if.sv
sv/cau_front.sv
sv/cau_div_step.sv
sv/complex_arithmetic_unit.sv
test/tb_complex_arithmetic_unit.sv
